@@ design/tdi_pkg.sv @@
// ----------------------------------------------------------------------------
// tdi_pkg
// Widths, status codes and stage word types for the depth interpolator.
// ----------------------------------------------------------------------------
package tdi_pkg;

  localparam int CoordBits      = 12;
  localparam int WeightFracBits = 24;
  localparam int InvFracBits    = 28;
  localparam int DepthFracBits  = 16;
  localparam int InvBits        = 32;
  localparam int DepthBits      = 32;

  localparam int XyBits   = 2 * CoordBits;
  localparam int AreaBits = 2 * CoordBits + 3;
  localparam int WtBits   = WeightFracBits + 1;
  localparam int ProdBits = InvBits + WtBits;
  localparam int SumBits  = ProdBits + 2;
  localparam int IvBits   = SumBits - WeightFracBits;
  localparam int RecipShift = DepthFracBits + InvFracBits - DepthBits;

  localparam logic [WtBits-1:0]    WtOne     = WtBits'(1) << WeightFracBits;
  localparam logic [IvBits-1:0]    RecipInit = IvBits'(1) << RecipShift;
  localparam logic [DepthBits-1:0] DepthSat  = '1;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StZeroArea = 2'd1;
  localparam logic [1:0] StNonPos   = 2'd2;
  localparam logic [1:0] StOverflow = 2'd3;

  typedef struct packed {
    logic                valid;
    logic [1:0]          status;
    logic [AreaBits-1:0] full;
    logic [AreaBits-1:0] au;
    logic [AreaBits-1:0] av;
  } tdi_area_t;

  typedef struct packed {
    logic                      valid;
    logic [1:0]                status;
    logic [AreaBits-1:0]       full;
    logic [AreaBits-1:0]       ru;
    logic [AreaBits-1:0]       rv;
    logic [WeightFracBits-1:0] qu;
    logic [WeightFracBits-1:0] qv;
    logic                      satu;
    logic                      satv;
  } tdi_div_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        status;
    logic [WtBits-1:0] u;
    logic [WtBits-1:0] v;
  } tdi_wt_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        status;
    logic [IvBits-1:0] inv;
  } tdi_inv_t;

  typedef struct packed {
    logic                 valid;
    logic [1:0]           status;
    logic [IvBits-1:0]    inv;
    logic [IvBits-1:0]    rem;
    logic [DepthBits-1:0] quo;
  } tdi_rcp_t;

endpackage

@@ design/tdi_area.sv @@
// ----------------------------------------------------------------------------
// tdi_area
// Three-stage signed area pipeline: differences, products, magnitudes.
// ----------------------------------------------------------------------------
module tdi_area import tdi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic [CoordBits-1:0] pixel_x_i,
  input  logic [CoordBits-1:0] pixel_y_i,
  input  logic [XyBits-1:0]    va_xy_i,
  input  logic [XyBits-1:0]    vb_xy_i,
  input  logic [XyBits-1:0]    vc_xy_i,
  output tdi_area_t            area_o
);

  localparam int DW = CoordBits + 1;
  localparam int PW = 2 * DW;

  logic                 v1_q, v2_q;
  logic signed [DW-1:0] dxc_q, dyb_q, dyc_q, dxb_q, dqx_q, dqy_q;
  logic signed [PW-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [AreaBits-1:0] sd_d, su_d, sv_d;
  tdi_area_t area_d, area_q;

  function automatic logic signed [DW-1:0] sub_c(logic [CoordBits-1:0] a,
                                                 logic [CoordBits-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  function automatic logic [AreaBits-1:0] mag(logic signed [AreaBits-1:0] s);
    return s[AreaBits-1] ? AreaBits'(-s) : AreaBits'(s);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dxc_q <= sub_c(vc_xy_i[XyBits-1:CoordBits], va_xy_i[XyBits-1:CoordBits]);
    dxb_q <= sub_c(vb_xy_i[XyBits-1:CoordBits], va_xy_i[XyBits-1:CoordBits]);
    dyc_q <= sub_c(vc_xy_i[CoordBits-1:0], va_xy_i[CoordBits-1:0]);
    dyb_q <= sub_c(vb_xy_i[CoordBits-1:0], va_xy_i[CoordBits-1:0]);
    dqx_q <= sub_c(pixel_x_i, va_xy_i[XyBits-1:CoordBits]);
    dqy_q <= sub_c(pixel_y_i, va_xy_i[CoordBits-1:0]);
    p0_q  <= PW'(dxc_q) * PW'(dyb_q);
    p1_q  <= PW'(dyc_q) * PW'(dxb_q);
    p2_q  <= PW'(dxc_q) * PW'(dqy_q);
    p3_q  <= PW'(dyc_q) * PW'(dqx_q);
    p4_q  <= PW'(dqx_q) * PW'(dyb_q);
    p5_q  <= PW'(dqy_q) * PW'(dxb_q);
  end

  always_comb begin
    sd_d          = AreaBits'(p0_q) - AreaBits'(p1_q);
    su_d          = AreaBits'(p2_q) - AreaBits'(p3_q);
    sv_d          = AreaBits'(p4_q) - AreaBits'(p5_q);
    area_d.valid  = v2_q;
    area_d.full   = mag(sd_d);
    area_d.au     = mag(su_d);
    area_d.av     = mag(sv_d);
    area_d.status = (sd_d == '0) ? StZeroArea : StOk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q <= '0;
    end else begin
      area_q <= area_d;
    end
  end

  assign area_o = area_q;

endmodule

@@ design/tdi_weight.sv @@
// ----------------------------------------------------------------------------
// tdi_weight
// Pipelined restoring dividers for both weights, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tdi_weight import tdi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tdi_area_t area_i,
  output tdi_wt_t   wt_o
);

  tdi_div_t st_q [WeightFracBits+1];
  tdi_div_t st0_d;

  always_comb begin
    st0_d        = '0;
    st0_d.valid  = area_i.valid;
    st0_d.status = area_i.status;
    st0_d.full   = area_i.full;
    st0_d.satu   = area_i.au >= area_i.full;
    st0_d.satv   = area_i.av >= area_i.full;
    st0_d.ru     = st0_d.satu ? '0 : area_i.au;
    st0_d.rv     = st0_d.satv ? '0 : area_i.av;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q[0] <= '0;
    end else begin
      st_q[0] <= st0_d;
    end
  end

  for (genvar i = 0; i < WeightFracBits; i++) begin : g_step
    logic [AreaBits:0] ru2, rv2;
    logic              bu, bv;
    tdi_div_t          nx;

    always_comb begin
      nx  = st_q[i];
      ru2 = {st_q[i].ru, 1'b0};
      rv2 = {st_q[i].rv, 1'b0};
      bu  = ru2 >= {1'b0, st_q[i].full};
      bv  = rv2 >= {1'b0, st_q[i].full};
      nx.ru = bu ? AreaBits'(ru2 - {1'b0, st_q[i].full}) : AreaBits'(ru2);
      nx.rv = bv ? AreaBits'(rv2 - {1'b0, st_q[i].full}) : AreaBits'(rv2);
      nx.qu = {st_q[i].qu[WeightFracBits-2:0], bu};
      nx.qv = {st_q[i].qv[WeightFracBits-2:0], bv};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[i+1] <= '0;
      end else begin
        st_q[i+1] <= nx;
      end
    end
  end

  always_comb begin
    wt_o.valid  = st_q[WeightFracBits].valid;
    wt_o.status = st_q[WeightFracBits].status;
    wt_o.u = st_q[WeightFracBits].satu ? WtOne : {1'b0, st_q[WeightFracBits].qu};
    wt_o.v = st_q[WeightFracBits].satv ? WtOne : {1'b0, st_q[WeightFracBits].qv};
  end

endmodule

@@ design/tdi_blend.sv @@
// ----------------------------------------------------------------------------
// tdi_blend
// Four-stage blend of the vertex inverse depths by the barycentric weights.
// ----------------------------------------------------------------------------
module tdi_blend import tdi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tdi_wt_t            wt_i,
  input  logic [InvBits-1:0] ia_i,
  input  logic [InvBits-1:0] ib_i,
  input  logic [InvBits-1:0] ic_i,
  output tdi_inv_t           inv_o
);

  logic                      va_q, vb_q, vc_q;
  logic [1:0]                sa_q, sb_q, sc_q;
  logic [WtBits-1:0]         u_q, v_q, w_q;
  logic                      wn_q, wnb_q;
  logic [ProdBits-1:0]       pa_q, pb_q, pc_q;
  logic [SumBits-1:0]        pos_q, neg_q, diff_d;
  logic signed [WtBits+1:0]  w0_d;
  tdi_inv_t                  inv_d, inv_q;

  always_comb begin
    w0_d = $signed({2'b0, WtOne}) - $signed({2'b0, wt_i.u})
         - $signed({2'b0, wt_i.v});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      va_q <= wt_i.valid;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sa_q  <= wt_i.status;
    u_q   <= wt_i.u;
    v_q   <= wt_i.v;
    wn_q  <= w0_d[WtBits+1];
    w_q   <= w0_d[WtBits+1] ? WtBits'(-w0_d) : WtBits'(w0_d);
    sb_q  <= sa_q;
    wnb_q <= wn_q;
    pa_q  <= ProdBits'(ia_i) * ProdBits'(w_q);
    pb_q  <= ProdBits'(ib_i) * ProdBits'(u_q);
    pc_q  <= ProdBits'(ic_i) * ProdBits'(v_q);
    sc_q  <= sb_q;
    pos_q <= SumBits'(pb_q) + SumBits'(pc_q) + (wnb_q ? '0 : SumBits'(pa_q));
    neg_q <= wnb_q ? SumBits'(pa_q) : '0;
  end

  always_comb begin
    diff_d       = pos_q - neg_q;
    inv_d.valid  = vc_q;
    inv_d.inv    = diff_d[SumBits-1:WeightFracBits];
    inv_d.status = sc_q;
    if (sc_q == StOk && pos_q <= neg_q) begin
      inv_d.status = StNonPos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= '0;
    end else begin
      inv_q <= inv_d;
    end
  end

  assign inv_o = inv_q;

endmodule

@@ design/tdi_recip.sv @@
// ----------------------------------------------------------------------------
// tdi_recip
// Pipelined restoring divider forming the Q16.16 depth, one bit per stage.
// ----------------------------------------------------------------------------
module tdi_recip import tdi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tdi_inv_t             inv_i,
  output logic                 valid_o,
  output logic [DepthBits-1:0] depth_o,
  output logic [1:0]           status_o
);

  tdi_rcp_t st_q [DepthBits+1];
  tdi_rcp_t st0_d;

  always_comb begin
    st0_d        = '0;
    st0_d.valid  = inv_i.valid;
    st0_d.inv    = inv_i.inv;
    st0_d.rem    = RecipInit;
    st0_d.status = inv_i.status;
    if (inv_i.status == StOk && inv_i.inv <= RecipInit) begin
      st0_d.status = StOverflow;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q[0] <= '0;
    end else begin
      st_q[0] <= st0_d;
    end
  end

  for (genvar i = 0; i < DepthBits; i++) begin : g_step
    logic [IvBits:0] r2;
    logic            b;
    tdi_rcp_t        nx;

    always_comb begin
      nx     = st_q[i];
      r2     = {st_q[i].rem, 1'b0};
      b      = r2 >= {1'b0, st_q[i].inv};
      nx.rem = b ? IvBits'(r2 - {1'b0, st_q[i].inv}) : IvBits'(r2);
      nx.quo = {st_q[i].quo[DepthBits-2:0], b};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[i+1] <= '0;
      end else begin
        st_q[i+1] <= nx;
      end
    end
  end

  assign valid_o  = st_q[DepthBits].valid;
  assign status_o = st_q[DepthBits].status;
  assign depth_o  = (st_q[DepthBits].status == StOk) ? st_q[DepthBits].quo : DepthSat;

endmodule

@@ design/triangle_depth_interpolator_unit.sv @@
// ----------------------------------------------------------------------------
// triangle_depth_interpolator_unit
// Pipeline from start to valid_o: 3 area stages, 25 weight divider
// stages, 4 blend stages and 33 reciprocal divider stages.
// Throughput one word per cycle; busy_o is always low, results cannot stall.
// Reset clears the pipeline valid bits; vertex registers reset to the origin
// and inverse depths to 1.0.
// ----------------------------------------------------------------------------
module triangle_depth_interpolator_unit import tdi_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [CoordBits-1:0] pixel_x_i,
  input  logic [CoordBits-1:0] pixel_y_i,
  output logic                 valid_o,
  output logic [DepthBits-1:0] depth_o,
  output logic [1:0]           status_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam logic [2:0] RegAXy  = 3'd0;
  localparam logic [2:0] RegBXy  = 3'd1;
  localparam logic [2:0] RegCXy  = 3'd2;
  localparam logic [2:0] RegAInv = 3'd3;
  localparam logic [2:0] RegBInv = 3'd4;
  localparam logic [2:0] RegCInv = 3'd5;
  localparam logic [InvBits-1:0] InvOne = InvBits'(1) << InvFracBits;

  logic [XyBits-1:0]  a_xy_q, b_xy_q, c_xy_q;
  logic [InvBits-1:0] a_inv_q, b_inv_q, c_inv_q;
  logic               wr_en;
  tdi_area_t          area;
  tdi_wt_t            wt;
  tdi_inv_t           inv;

  assign pready = 1'b1;
  assign busy_o = 1'b0;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_xy_q  <= '0;
      b_xy_q  <= '0;
      c_xy_q  <= '0;
      a_inv_q <= InvOne;
      b_inv_q <= InvOne;
      c_inv_q <= InvOne;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        RegAXy:  a_xy_q  <= pwdata[XyBits-1:0];
        RegBXy:  b_xy_q  <= pwdata[XyBits-1:0];
        RegCXy:  c_xy_q  <= pwdata[XyBits-1:0];
        RegAInv: a_inv_q <= pwdata;
        RegBInv: b_inv_q <= pwdata;
        RegCInv: c_inv_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      RegAXy:  prdata = 32'(a_xy_q);
      RegBXy:  prdata = 32'(b_xy_q);
      RegCXy:  prdata = 32'(c_xy_q);
      RegAInv: prdata = a_inv_q;
      RegBInv: prdata = b_inv_q;
      RegCInv: prdata = c_inv_q;
      default: prdata = '0;
    endcase
  end

  tdi_area u_area (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start_i & ~busy_o),
    .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i),
    .va_xy_i   (a_xy_q),
    .vb_xy_i   (b_xy_q),
    .vc_xy_i   (c_xy_q),
    .area_o    (area)
  );

  tdi_weight u_weight (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .area_i (area),
    .wt_o   (wt)
  );

  tdi_blend u_blend (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wt_i   (wt),
    .ia_i   (a_inv_q),
    .ib_i   (b_inv_q),
    .ic_i   (c_inv_q),
    .inv_o  (inv)
  );

  tdi_recip u_recip (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .inv_i    (inv),
    .valid_o  (valid_o),
    .depth_o  (depth_o),
    .status_o (status_o)
  );

endmodule

@@ verif/tb_triangle_depth_interpolator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_depth_interpolator_unit
// Drives pixels through the depth interpolator under several triangle and
// inverse-depth settings, predicts depth and status per pixel and checks
// every result word in order.
// ----------------------------------------------------------------------------
module tb_triangle_depth_interpolator_unit;
  import tdi_pkg::*;

  localparam int LatencyCycles = 65;
  localparam int CycleLimit    = 400000;

  typedef enum logic [4:0] {
    RegVaXy  = 5'd0,
    RegVbXy  = 5'd4,
    RegVcXy  = 5'd8,
    RegVaInv = 5'd12,
    RegVbInv = 5'd16,
    RegVcInv = 5'd20
  } reg_addr_e;

  typedef struct packed {
    logic [DepthBits-1:0] depth;
    logic [1:0]           status;
  } depth_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic [CoordBits-1:0] pixel_x_i = '0;
  logic [CoordBits-1:0] pixel_y_i = '0;
  logic                 valid_o;
  logic [DepthBits-1:0] depth_o;
  logic [1:0]           status_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [4:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  logic [XyBits-1:0]  tri_xy [3];
  logic [InvBits-1:0] tri_inv [3];
  depth_word_t        depth_queue [$];
  int                 error_count = 0;
  int                 cycle_count = 0;
  bit                 no_idle = 1'b0;

  triangle_depth_interpolator_unit DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_triangle_depth_interpolator_unit: errors");
      $finish;
    end
  end

  function automatic longint unsigned abs_area(longint signed a);
    return a < 0 ? longint'(-a) : longint'(a);
  endfunction

  function automatic longint unsigned bary_weight(longint unsigned area,
                                                  longint unsigned full);
    if (area >= full) return 64'd1 << WeightFracBits;
    return (area << WeightFracBits) / full;
  endfunction

  function automatic depth_word_t predict_depth(logic [CoordBits-1:0] px,
                                                logic [CoordBits-1:0] py);
    longint signed xa, ya, xb, yb, xc, yc, qx, qy, w0;
    longint unsigned full, u, v, pos, neg, inv, dq;
    depth_word_t r;
    xa = longint'(tri_xy[0][23:12]); ya = longint'(tri_xy[0][11:0]);
    xb = longint'(tri_xy[1][23:12]); yb = longint'(tri_xy[1][11:0]);
    xc = longint'(tri_xy[2][23:12]); yc = longint'(tri_xy[2][11:0]);
    qx = longint'(px); qy = longint'(py);
    r.depth = DepthSat;
    full = abs_area((xc - xa) * (yb - ya) - (yc - ya) * (xb - xa));
    if (full == 0) begin
      r.status = StZeroArea;
      return r;
    end
    u = bary_weight(abs_area((xc - xa) * (qy - ya) - (yc - ya) * (qx - xa)), full);
    v = bary_weight(abs_area((qx - xa) * (yb - ya) - (qy - ya) * (xb - xa)), full);
    w0 = (longint'(1) << WeightFracBits) - longint'(u) - longint'(v);
    pos = longint'(tri_inv[1]) * u + longint'(tri_inv[2]) * v;
    neg = 0;
    if (w0 >= 0) pos += longint'(tri_inv[0]) * longint'(w0);
    else neg = longint'(tri_inv[0]) * longint'(-w0);
    if (pos <= neg) begin
      r.status = StNonPos;
      return r;
    end
    inv = (pos - neg) >> WeightFracBits;
    if (inv == 0) begin
      r.status = StOverflow;
      return r;
    end
    dq = (64'd1 << (DepthFracBits + InvFracBits)) / inv;
    if (dq > 64'hFFFF_FFFF) begin
      r.status = StOverflow;
      return r;
    end
    r.depth = dq[31:0];
    r.status = StOk;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    error_count++;
  endtask

  always @(posedge clk_i) begin
    depth_word_t want;
    if (rst_ni && valid_o) begin
      if (depth_queue.size() == 0) begin
        report_mismatch("unexpected word", depth_o, 32'd0);
      end else begin
        want = depth_queue.pop_front();
        if (depth_o !== want.depth) report_mismatch("depth", depth_o, want.depth);
        if (status_o !== want.status) begin
          report_mismatch("status", 32'(status_o), 32'(want.status));
        end
      end
    end
  end

  task automatic write_reg(reg_addr_e addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (addr)
      RegVaXy:  tri_xy[0] = data[XyBits-1:0];
      RegVbXy:  tri_xy[1] = data[XyBits-1:0];
      RegVcXy:  tri_xy[2] = data[XyBits-1:0];
      RegVaInv: tri_inv[0] = data;
      RegVbInv: tri_inv[1] = data;
      default:  tri_inv[2] = data;
    endcase
  endtask

  task automatic send_pixel(logic [CoordBits-1:0] px, logic [CoordBits-1:0] py);
    while (!no_idle && $urandom_range(99) < 7) begin
      @(posedge clk_i);
      start_i <= 1'b0;
    end
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    start_i <= 1'b1; pixel_x_i <= px; pixel_y_i <= py;
    depth_queue.push_back(predict_depth(px, py));
  endtask

  task automatic drain();
    @(posedge clk_i);
    start_i <= 1'b0;
    while (depth_queue.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles + 5) @(posedge clk_i);
  endtask

  task automatic set_triangle(logic [11:0] ax, ay, bx, by, cx, cy,
                              logic [31:0] ia, ib, ic);
    write_reg(RegVaXy, {ax, ay});
    write_reg(RegVbXy, {bx, by});
    write_reg(RegVcXy, {cx, cy});
    write_reg(RegVaInv, ia);
    write_reg(RegVbInv, ib);
    write_reg(RegVcInv, ic);
  endtask

  task automatic test_zero_area();
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    drain();
  endtask

  task automatic test_directed();
    set_triangle(12'd0, 12'd0, 12'hFFF, 12'd0, 12'd0, 12'hFFF,
                 32'h1000_0000, 32'h2000_0000, 32'h0800_0000);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'd0, 12'hFFF);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd100, 12'd200);
    send_pixel(12'hAAA, 12'h555);
    drain();
    set_triangle(12'd10, 12'd10, 12'd20, 12'd10, 12'd10, 12'd20,
                 32'hFFFF_FFFF, 32'd0, 32'd0);
    send_pixel(12'd12, 12'd12);
    send_pixel(12'd30, 12'd30);
    send_pixel(12'hFFF, 12'hFFF);
    drain();
    set_triangle(12'd0, 12'd0, 12'd1, 12'd0, 12'd0, 12'd1, 32'd1, 32'd1, 32'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    drain();
    set_triangle(12'hFFF, 12'hFFF, 12'd0, 12'hFFF, 12'hFFF, 12'd0,
                 32'd0, 32'h0000_0100, 32'hFFFF_FFFF);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'h800, 12'h800);
    drain();
  endtask

  task automatic test_random(int phases, int per_phase);
    logic [11:0] c [6];
    logic [31:0] iv [3];
    logic [11:0] lo, hi;
    for (int p = 0; p < phases; p++) begin
      lo = 12'($urandom_range(4000));
      hi = lo + 12'($urandom_range(4095 - 32'(lo)));
      foreach (c[i]) c[i] = (p % 4 == 0) ? 12'($urandom) : 12'($urandom_range(hi, lo));
      foreach (iv[i]) iv[i] = (p % 3 == 0) ? $urandom : $urandom_range(32'h2000_0000, 1);
      set_triangle(c[0], c[1], c[2], c[3], c[4], c[5], iv[0], iv[1], iv[2]);
      no_idle = (p == 1);
      for (int k = 0; k < per_phase; k++) begin
        if ($urandom_range(3) == 0) send_pixel(12'($urandom), 12'($urandom));
        else send_pixel(12'($urandom_range(hi, lo)), 12'($urandom_range(hi, lo)));
      end
      no_idle = 1'b0;
      drain();
    end
  endtask

  initial begin
    tri_xy = '{default: '0};
    tri_inv = '{default: 32'h1000_0000};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_zero_area();
    test_directed();
    test_random(24, 60);
    if (error_count == 0) begin
      $display("tb_triangle_depth_interpolator_unit: clean");
    end else begin
      $display("tb_triangle_depth_interpolator_unit: errors");
    end
    $finish;
  end

endmodule
